>>> sv/jsj_pkg.sv
package jsj_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 10;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEAD_BAND      = 3'd0,
    REG_BASE_LOWER     = 3'd1,
    REG_BASE_UPPER     = 3'd2,
    REG_SHOULDER_LOWER = 3'd3,
    REG_SHOULDER_UPPER = 3'd4,
    REG_ELBOW_PERIOD   = 3'd5,
    REG_STICK_Y_ZERO   = 3'd6,
    REG_TILT_Y_ZERO    = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [6:0] DeadBandRst      = 7'd50;
  localparam logic [7:0] BaseLowerRst     = 8'd0;
  localparam logic [7:0] BaseUpperRst     = 8'd180;
  localparam logic [7:0] ShoulderLowerRst = 8'd70;
  localparam logic [7:0] ShoulderUpperRst = 8'd180;
  localparam logic [7:0] ElbowPeriodRst   = 8'd6;
  localparam logic [9:0] StickYZeroRst    = 10'd515;
  localparam logic [9:0] TiltYZeroRst     = 10'd400;

  // servo state after reset
  localparam logic [7:0] BasePosRst     = 8'd90;
  localparam logic [7:0] ShoulderPosRst = 8'd120;
  localparam logic [7:0] ElbowPosRst    = 8'd60;

  localparam logic [2:0] MinBytes  = 3'd5;
  localparam logic [7:0] ElbowMax  = 8'd180;

  typedef struct packed {
    logic [7:0] stick_x_byte;
    logic [7:0] stick_y_byte;
    logic [7:0] tilt_y_byte;
    logic [7:0] packed_bits;
    logic [2:0] bytes_received;
  } in_item_t;

  typedef struct packed {
    logic [7:0] base_angle;
    logic [7:0] shoulder_angle;
    logic [7:0] elbow_angle;
    logic       elbow_updated;
    logic       z_pressed;
  } out_item_t;

endpackage

>>> sv/joystick_servo_jog_core.sv
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid / in_ready    | jsj_pkg::in_item_t
// out     | output    | out_valid / out_ready  | jsj_pkg::out_item_t
// cfg     | input     | cfg_we (always taken)  | cfg_index, cfg_data
//
// One report per cycle while in_ready is high; a kept report shows up on out in the cycle after it is taken.
// All math is combinational from the input port into the state and result registers.
// A short report (under five bytes) is taken and dropped with no state change.
// in_ready drops only while a result sits in the output register with out_ready low.
// Synchronous reset restores registers and servo positions and empties the output.
module joystick_servo_jog_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  jsj_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output jsj_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [jsj_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [jsj_pkg::CfgDataWidth-1:0]     cfg_data
);
  import jsj_pkg::*;

  // (t * 200) / 1024 - 100, division truncating toward zero
  function automatic logic signed [9:0] stick_map(input logic signed [11:0] t);
    logic signed [19:0] p;
    logic signed [19:0] q;
    p = 20'(t) * 20'sd200;
    if (p[19]) begin
      q = (p + 20'sd1023) >>> 10;
    end else begin
      q = p >>> 10;
    end
    return q[9:0] - 10'sd100;
  endfunction

  function automatic logic [7:0] jog(input logic [7:0] pos, input logic signed [9:0] m,
                                     input logic [7:0] lo, input logic [7:0] hi,
                                     input logic [6:0] db);
    logic signed [9:0] dbs;
    logic signed [9:0] p;
    logic              up;
    logic              down;
    dbs  = signed'({3'b000, db});
    up   = (m <= -dbs);
    down = (m > dbs);
    if (!(up || down)) begin
      return pos;
    end
    p = signed'({2'b00, pos}) + (up ? 10'sd1 : -10'sd1);
    if (p > signed'({2'b00, hi})) begin
      p = signed'({2'b00, hi});
    end
    if (p < signed'({2'b00, lo})) begin
      p = signed'({2'b00, lo});
    end
    return p[7:0];
  endfunction

  logic [6:0] dead_band;
  logic [7:0] base_lower, base_upper, shoulder_lower, shoulder_upper, elbow_period;
  logic [9:0] stick_y_zero, tilt_y_zero;
  logic [7:0] base_pos, shoulder_pos, elbow_pos, elbow_tick;

  logic       in_fire, keep;
  logic [1:0] stick_low;
  logic [9:0] raw_x, raw_y, raw_t;
  logic signed [11:0] tx, ty, ta;
  logic signed [9:0]  map_x, map_y;
  logic [10:0] ta_pos;
  logic [25:0] ta_scaled;
  logic [9:0]  ta_div5;
  logic [7:0]  elbow_new;
  logic [7:0]  base_pos_next, shoulder_pos_next, elbow_pos_next, elbow_tick_next;
  logic [7:0]  tick_inc;
  logic        elbow_upd;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign keep     = in_data.bytes_received >= MinBytes;

  always_comb begin
    stick_low = in_data.packed_bits[3:2];
    raw_x = {in_data.stick_x_byte, stick_low};
    raw_y = {in_data.stick_y_byte, stick_low};
    raw_t = {in_data.tilt_y_byte, in_data.packed_bits[5:4]};
    // offset by +512 folded in: X zero is fixed at 512
    tx = signed'({2'b00, raw_x});
    ty = signed'({2'b00, raw_y}) - signed'({2'b00, stick_y_zero}) + 12'sd512;
    ta = signed'({2'b00, raw_t}) - signed'({2'b00, tilt_y_zero}) + 12'sd300;
    map_x = stick_map(tx);
    map_y = stick_map(ty);

    base_pos_next     = jog(base_pos, map_x, base_lower, base_upper, dead_band);
    shoulder_pos_next = jog(shoulder_pos, map_y, shoulder_lower, shoulder_upper, dead_band);

    // elbow angle = ta / 5, 13108/65536 reciprocal is exact for ta < 2048
    ta_pos    = ta[10:0];
    ta_scaled = 26'(ta_pos) * 26'd13108;
    ta_div5   = ta_scaled[25:16];
    if (ta[11] || ta == 12'sd0) begin
      elbow_new = 8'd0;
    end else if (ta_div5 > 10'(ElbowMax)) begin
      elbow_new = ElbowMax;
    end else begin
      elbow_new = ta_div5[7:0];
    end

    tick_inc  = elbow_tick + 8'd1;
    elbow_upd = tick_inc >= elbow_period;
    elbow_tick_next = elbow_upd ? 8'd0 : tick_inc;
    elbow_pos_next  = elbow_upd ? elbow_new : elbow_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band      <= DeadBandRst;
      base_lower     <= BaseLowerRst;
      base_upper     <= BaseUpperRst;
      shoulder_lower <= ShoulderLowerRst;
      shoulder_upper <= ShoulderUpperRst;
      elbow_period   <= ElbowPeriodRst;
      stick_y_zero   <= StickYZeroRst;
      tilt_y_zero    <= TiltYZeroRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEAD_BAND:      dead_band      <= cfg_data[6:0];
        REG_BASE_LOWER:     base_lower     <= cfg_data[7:0];
        REG_BASE_UPPER:     base_upper     <= cfg_data[7:0];
        REG_SHOULDER_LOWER: shoulder_lower <= cfg_data[7:0];
        REG_SHOULDER_UPPER: shoulder_upper <= cfg_data[7:0];
        REG_ELBOW_PERIOD:   elbow_period   <= cfg_data[7:0];
        REG_STICK_Y_ZERO:   stick_y_zero   <= cfg_data;
        REG_TILT_Y_ZERO:    tilt_y_zero    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pos     <= BasePosRst;
      shoulder_pos <= ShoulderPosRst;
      elbow_pos    <= ElbowPosRst;
      elbow_tick   <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire && keep) begin
        base_pos     <= base_pos_next;
        shoulder_pos <= shoulder_pos_next;
        elbow_pos    <= elbow_pos_next;
        elbow_tick   <= elbow_tick_next;
        out_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && keep) begin
      out_data.base_angle     <= base_pos_next;
      out_data.shoulder_angle <= shoulder_pos_next;
      out_data.elbow_angle    <= elbow_pos_next;
      out_data.elbow_updated  <= elbow_upd;
      out_data.z_pressed      <= !in_data.packed_bits[0];
    end
  end

endmodule

>>> sv/jsj_checker.sv
module jsj_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input jsj_pkg::in_item_t                 in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input jsj_pkg::out_item_t                out_data
);
  import jsj_pkg::*;

  logic in_fire;
  logic kept;
  assign in_fire = in_valid && in_ready;
  assign kept    = in_data.bytes_received >= MinBytes;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output not empty after reset");

  a_kept_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && kept |=> out_valid)
    else $error("kept report gave no result");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && !kept && (!out_valid || out_ready) |=> !out_valid)
    else $error("dropped report gave a result");

  a_z_button: assert property (@(posedge clk) disable iff (rst)
    in_fire && kept |=> out_data.z_pressed == !$past(in_data.packed_bits[0]))
    else $error("z_pressed does not follow report");

endmodule

bind joystick_servo_jog_core jsj_checker u_jsj_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
